FILE: sv/bxp_pkg.sv
package bxp_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned PopW       = 6;
  localparam int unsigned DotW       = 17;
  localparam int unsigned MaxWordsDef = 1024;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [WordW-1:0] a_word;
    logic [WordW-1:0] b_word;
    logic             last_word;
  } in_item_t;

  typedef struct packed {
    logic signed [DotW-1:0] dot_product;
    logic                   overflow;
  } out_item_t;

  // One classified word on its way from the front to the accumulator.
  typedef struct packed {
    logic [PopW-1:0] mismatches;
    logic            last_word;
  } work_t;

  // Bit count of a 32-bit word as an adder tree: pairs, nibbles, bytes, then a sum of bytes.
  function automatic logic [PopW-1:0] popcount32(input logic [WordW-1:0] v);
    logic [31:0] s2;
    logic [31:0] s4;
    logic [31:0] s8;
    logic [PopW-1:0] lo;
    logic [PopW-1:0] hi;
    s2 = v - ((v >> 1) & 32'h5555_5555);
    s4 = (s2 & 32'h3333_3333) + ((s2 >> 2) & 32'h3333_3333);
    s8 = (s4 + (s4 >> 4)) & 32'h0F0F_0F0F;
    lo = PopW'(s8[7:0]) + PopW'(s8[15:8]);
    hi = PopW'(s8[23:16]) + PopW'(s8[31:24]);
    return lo + hi;
  endfunction

endpackage

FILE: sv/binary_xnor_popcount_dot.sv
// Channel | Handshake                  | Payload
// --------+----------------------------+--------------------------------------
// input   | in_valid_i / in_ready_o    | in_item_i  (a_word, b_word, last_word)
// output  | out_valid_o / out_ready_i  | out_item_o (dot_product, overflow)
//
// One word can be taken every cycle while the queue has room; its popcount is formed as it enters the queue.
// The back end accumulates each word as it leaves the queue; a last word loads the registered
// result and raises out_valid_o, and the result stays until out_ready_i takes it.
// Reset clears the queue, the accumulators and the output valid; no clearing pass.
// A stalled output blocks only last words; the two-entry queue absorbs the rest.
module binary_xnor_popcount_dot #(
  parameter int unsigned MaxWords = bxp_pkg::MaxWordsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bxp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bxp_pkg::out_item_t out_item_o
);

  logic           push_valid, push_ready;
  bxp_pkg::work_t push_item;
  logic           pop_valid, pop_ready;
  bxp_pkg::work_t pop_item;

  bxp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  bxp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  bxp_back #(
    .MaxWords (MaxWords)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: sv/bxp_front.sv
module bxp_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bxp_pkg::in_item_t in_item_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output bxp_pkg::work_t    push_item_o
);

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_item_o.mismatches = bxp_pkg::popcount32(in_item_i.a_word ^ in_item_i.b_word);
    push_item_o.last_word  = in_item_i.last_word;
  end

endmodule

FILE: sv/bxp_fifo.sv
module bxp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bxp_pkg::work_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bxp_pkg::work_t pop_item_o
);

  localparam int unsigned Depth = bxp_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bxp_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on a lone push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with mismatched pointers");

endmodule

FILE: sv/bxp_back.sv
module bxp_back #(
  parameter int unsigned MaxWords = bxp_pkg::MaxWordsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  bxp_pkg::work_t     pop_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bxp_pkg::out_item_t out_item_o
);

  localparam int unsigned WcW  = $clog2(MaxWords + 1);
  localparam int unsigned MtW  = $clog2(MaxWords * 32 + 1);
  localparam int unsigned DotW = bxp_pkg::DotW;

  logic [WcW-1:0] wc_q, wc_d, wc_upd;
  logic [MtW-1:0] mt_q, mt_d, mt_upd;
  logic           ovf_q, ovf_d, ovf_upd;
  logic           out_valid_q, out_valid_d;
  bxp_pkg::out_item_t out_q, out_d;
  logic           at_max;
  logic           take;
  logic [DotW-1:0] dot;

  assign at_max = (wc_q == WcW'(MaxWords));
  // A last word needs a free output slot; other words never wait.
  assign pop_ready_o = !pop_item_i.last_word || !out_valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  assign wc_upd  = at_max ? wc_q : wc_q + 1'b1;
  assign mt_upd  = at_max ? mt_q : mt_q + MtW'(pop_item_i.mismatches);
  assign ovf_upd = ovf_q | at_max;
  assign dot     = (DotW'(wc_upd) << 5) - (DotW'(mt_upd) << 1);

  always_comb begin
    wc_d        = wc_q;
    mt_d        = mt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (take) begin
      if (pop_item_i.last_word) begin
        wc_d              = '0;
        mt_d              = '0;
        ovf_d             = 1'b0;
        out_valid_d       = 1'b1;
        out_d.dot_product = $signed(dot);
        out_d.overflow    = ovf_upd;
      end else begin
        wc_d  = wc_upd;
        mt_d  = mt_upd;
        ovf_d = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q        <= '0;
      mt_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wc_q        <= wc_d;
      mt_q        <= mt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) wc_q <= WcW'(MaxWords))
    else $error("word count passed its limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni) ovf_q |-> at_max)
    else $error("overflow flagged below the word limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && pop_item_i.last_word) |=> (wc_q == '0 && mt_q == '0 && out_valid_q))
    else $error("last word did not clear state and post a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mt_q <= MtW'(32) * MtW'(wc_q))
    else $error("mismatch total exceeds the counted bits");

endmodule
